>>> hdl/oaids_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package oaids_pkg;

  localparam int DEPTH   = 64;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int MODE_W  = 3;
  localparam int POS_W   = 7;
  localparam int STAT_W  = 3;
  localparam int ECNT_W  = 7;
  // compare width: holds position, count and count+1 without wrap
  localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR   = 3'd0,
    MODE_INSERT  = 3'd1,
    MODE_DELETE  = 3'd2,
    MODE_SEARCH  = 3'd3,
    MODE_DISPLAY = 3'd4
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    status_e           status;
    logic [POS_W-1:0]  found;
    logic [DATA_W-1:0] element;
    logic [CNT_W-1:0]  count;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/ordered_array_insert_delete_search_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake                  Beat payload
// -------  -------------------------  ------------------------------------------------
// in       in_valid_i / in_ready_o    mode_i, position_i, value_i
// out      out_valid_o / out_ready_i  status_o, found_position_o, element_o,
//                                     element_count_o, last_o
//
// One item at a time. Clear or a rejected op goes from decode straight to the
// response, which waits out output stalls. Insert and delete move entries one
// by one, a read then a write each; search reads entries in order up to the
// first match; display reads and emits each entry in turn. All use one RAM port.
// Reset clears the count and control; store contents are kept across reset
// and are never read past the count. A stalled out beat holds in the output
// register and a new in beat is taken as soon as the sequencer is idle.
module ordered_array_insert_delete_search_top import oaids_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [MODE_W-1:0]        mode_i,
  input  wire logic [POS_W-1:0]         position_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [STAT_W-1:0]             status_o,
  output logic [POS_W-1:0]              found_position_o,
  output logic signed [DATA_W-1:0]      element_o,
  output logic [ECNT_W-1:0]             element_count_o,
  output logic                          last_o
);

  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;
  res_t              res;
  logic              res_push;
  logic              res_free;

  res_t              out_q;
  logic              out_valid_q;

  // element store
  oaids_ram #(
    .DW (DATA_W),
    .AW (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (mem_req.en),
    .we_i    (mem_req.we),
    .addr_i  (mem_req.addr),
    .wdata_i (mem_req.wdata),
    .rdata_o (mem_rdata)
  );

  oaids_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .pos_i       (position_i),
    .val_i       (value_i),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_free_i  (res_free),
    .res_push_o  (res_push),
    .res_o       (res)
  );

  // output register: free when empty or being drained this cycle
  assign res_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign found_position_o = out_q.found;
  assign element_o        = out_q.element;
  assign element_count_o  = ECNT_W'(out_q.count);
  assign last_o           = out_q.last;

endmodule

`default_nettype wire

>>> hdl/oaids_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Single-port RAM with registered read data. Read data holds until the next read.
module oaids_ram #(
  parameter int DW = 32,
  parameter int AW = 6
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [DW-1:0] wdata_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/oaids_seq.sv
`timescale 1ns / 1ps
`default_nettype none

// Operation sequencer: decodes an item, walks the store, pushes results.
module oaids_seq import oaids_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [MODE_W-1:0] mode_i,
  input  wire logic [POS_W-1:0]  pos_i,
  input  wire logic [DATA_W-1:0] val_i,
  output mem_req_t               mem_req_o,
  input  wire logic [DATA_W-1:0] mem_rdata_i,
  input  wire logic              res_free_i,
  output logic                   res_push_o,
  output res_t                   res_o
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_DEC    = 10'b00_0000_0010,
    S_INS_RD = 10'b00_0000_0100,
    S_INS_WR = 10'b00_0000_1000,
    S_DEL_RD = 10'b00_0001_0000,
    S_DEL_WR = 10'b00_0010_0000,
    S_SRCH   = 10'b00_0100_0000,
    S_DSP_RD = 10'b00_1000_0000,
    S_DSP_EM = 10'b01_0000_0000,
    S_RESP   = 10'b10_0000_0000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    cmp_idx_q, cmp_idx_d;
  logic                rd_vld_q, rd_vld_d;
  logic [MODE_W-1:0]   mode_q, mode_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [DATA_W-1:0]   val_q, val_d;
  status_e             rstat_q, rstat_d;
  logic [POS_W-1:0]    rfound_q, rfound_d;

  logic [CNT_W-1:0]    idx_m1, idx_p1;
  logic [CMP_W-1:0]    pos_x, cnt_x, idx_x, pos_m1;

  assign idx_m1 = idx_q - 1'b1;
  assign idx_p1 = idx_q + 1'b1;
  assign pos_x  = CMP_W'(pos_q);
  assign cnt_x  = CMP_W'(count_q);
  assign idx_x  = CMP_W'(idx_q);
  assign pos_m1 = pos_x - 1'b1;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    idx_d     = idx_q;
    cmp_idx_d = cmp_idx_q;
    rd_vld_d  = rd_vld_q;
    mode_d    = mode_q;
    pos_d     = pos_q;
    val_d     = val_q;
    rstat_d   = rstat_q;
    rfound_d  = rfound_q;
    mem_req_o = '0;
    res_push_o = 1'b0;
    res_o         = '0;
    res_o.status  = ST_OK;
    res_o.count   = count_q;
    res_o.last    = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d  = mode_i;
          pos_d   = pos_i;
          val_d   = val_i;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        rfound_d = '0;
        rstat_d  = ST_OK;
        state_d  = S_RESP;
        case (mode_q)
          MODE_CLEAR: begin
            count_d = '0;
          end
          MODE_INSERT: begin
            if (cnt_x == CMP_W'(DEPTH)) begin
              rstat_d = ST_FULL;
            end else if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
              rstat_d = ST_BADPOS;
            end else begin
              idx_d   = count_q;
              state_d = S_INS_RD;
            end
          end
          MODE_DELETE: begin
            if (count_q == '0) begin
              rstat_d = ST_EMPTY;
            end else if (pos_x == '0 || pos_x > cnt_x) begin
              rstat_d = ST_BADPOS;
            end else begin
              idx_d   = CNT_W'(pos_m1);
              state_d = S_DEL_RD;
            end
          end
          MODE_SEARCH: begin
            if (count_q == '0) begin
              rstat_d = ST_EMPTY;
            end else begin
              idx_d    = '0;
              rd_vld_d = 1'b0;
              state_d  = S_SRCH;
            end
          end
          MODE_DISPLAY: begin
            if (count_q == '0) begin
              rstat_d = ST_EMPTY;
            end else begin
              idx_d   = '0;
              state_d = S_DSP_RD;
            end
          end
          default: begin
            rstat_d = ST_BADPOS;
          end
        endcase
      end
      // shift up: entry idx takes entry idx-1, from the top down to pos
      S_INS_RD: begin
        if (idx_x >= pos_x) begin
          mem_req_o.en   = 1'b1;
          mem_req_o.addr = idx_m1[ADDR_W-1:0];
          state_d        = S_INS_WR;
        end else begin
          mem_req_o.en    = 1'b1;
          mem_req_o.we    = 1'b1;
          mem_req_o.addr  = pos_m1[ADDR_W-1:0];
          mem_req_o.wdata = val_q;
          count_d         = count_q + 1'b1;
          state_d         = S_RESP;
        end
      end
      S_INS_WR: begin
        mem_req_o.en    = 1'b1;
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = idx_q[ADDR_W-1:0];
        mem_req_o.wdata = mem_rdata_i;
        idx_d           = idx_m1;
        state_d         = S_INS_RD;
      end
      // shift down: entry idx takes entry idx+1 up to the end
      S_DEL_RD: begin
        if (idx_p1 < count_q) begin
          mem_req_o.en   = 1'b1;
          mem_req_o.addr = idx_p1[ADDR_W-1:0];
          state_d        = S_DEL_WR;
        end else begin
          count_d = count_q - 1'b1;
          state_d = S_RESP;
        end
      end
      S_DEL_WR: begin
        mem_req_o.en    = 1'b1;
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = idx_q[ADDR_W-1:0];
        mem_req_o.wdata = mem_rdata_i;
        idx_d           = idx_p1;
        state_d         = S_DEL_RD;
      end
      // pipelined scan: read idx while comparing the entry read last cycle
      S_SRCH: begin
        if (rd_vld_q && mem_rdata_i == val_q) begin
          rfound_d = POS_W'(cmp_idx_q + 1'b1);
          rstat_d  = ST_OK;
          rd_vld_d = 1'b0;
          state_d  = S_RESP;
        end else if (idx_q < count_q) begin
          mem_req_o.en   = 1'b1;
          mem_req_o.addr = idx_q[ADDR_W-1:0];
          cmp_idx_d      = idx_q;
          idx_d          = idx_p1;
          rd_vld_d       = 1'b1;
        end else begin
          rstat_d  = ST_NOTFOUND;
          rd_vld_d = 1'b0;
          state_d  = S_RESP;
        end
      end
      S_DSP_RD: begin
        mem_req_o.en   = 1'b1;
        mem_req_o.addr = idx_q[ADDR_W-1:0];
        state_d        = S_DSP_EM;
      end
      S_DSP_EM: begin
        res_o.element = mem_rdata_i;
        res_o.last    = (idx_p1 == count_q);
        if (res_free_i) begin
          res_push_o = 1'b1;
          idx_d      = idx_p1;
          state_d    = (idx_p1 == count_q) ? S_IDLE : S_DSP_RD;
        end
      end
      S_RESP: begin
        res_o.status = rstat_q;
        res_o.found  = rfound_q;
        if (res_free_i) begin
          res_push_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    cmp_idx_q <= cmp_idx_d;
    mode_q    <= mode_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    rstat_q   <= rstat_d;
    rfound_q  <= rfound_d;
  end

endmodule

`default_nettype wire

>>> hdl/oaids_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module oaids_chk import oaids_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     out_valid_o,
  input wire logic                     out_ready_i,
  input wire logic [STAT_W-1:0]        status_o,
  input wire logic [POS_W-1:0]         found_position_o,
  input wire logic signed [DATA_W-1:0] element_o,
  input wire logic [ECNT_W-1:0]        element_count_o,
  input wire logic                     last_o
);

  // stalled out beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(element_o) && $stable(element_count_o) && $stable(last_o))
    else $error("out beat changed while stalled");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> element_count_o <= ECNT_W'(DEPTH))
    else $error("element count above depth");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_position_o != '0 |->
      status_o == ST_OK && found_position_o <= element_count_o)
    else $error("found position without a successful search");

  a_run_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> status_o == ST_OK && found_position_o == '0)
    else $error("non-final beat outside a display run");

  a_elem_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && element_o != '0 |-> status_o == ST_OK && element_count_o != '0)
    else $error("element on a non-display beat");

endmodule

bind ordered_array_insert_delete_search_top oaids_chk u_oaids_chk (.*);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import oaids_pkg::*;

  // Undefined opcodes: the block must reject them with a bad-position status.
  localparam logic [MODE_W-1:0] MODE_UNDEF_LO  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_UNDEF_MID = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNDEF_HI  = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic [POS_W-1:0]         POS_ALL = 7'h7F;

  // Worst single op: insert at position 1 of an array holding 63 entries.
  localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
  // Watchdog limit, well above the slowest legal run.
  localparam int WATCHDOG_NS  = 10_000_000;

  // One expected out beat.
  typedef struct {
    status_e                  status;
    logic [POS_W-1:0]         found;
    logic signed [DATA_W-1:0] element;
    logic [ECNT_W-1:0]        count;
    logic                     last;
  } result_beat_t;

  // Directed stimulus row. Where typed is set, the single result is known up
  // front (element is zero, last is one); otherwise the array model decides.
  typedef struct {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    logic                     typed;
    status_e                  status;
    logic [POS_W-1:0]         found;
    logic [ECNT_W-1:0]        count;
  } op_row_t;

  localparam int N_DIRECTED = 26;

  op_row_t directed_ops [N_DIRECTED] = '{
    // empty array: every reader reports empty
    '{MODE_SEARCH,    7'd0,    32'sd5,        1'b1, ST_EMPTY,    7'd0, 7'd0},
    '{MODE_DISPLAY,   7'd0,    32'sd0,        1'b1, ST_EMPTY,    7'd0, 7'd0},
    '{MODE_DELETE,    7'd1,    32'sd0,        1'b1, ST_EMPTY,    7'd0, 7'd0},
    // insert position checks on an empty array
    '{MODE_INSERT,    7'd0,    32'sd9,        1'b1, ST_BADPOS,   7'd0, 7'd0},
    '{MODE_INSERT,    7'd2,    32'sd9,        1'b1, ST_BADPOS,   7'd0, 7'd0},
    // build [MIN, -1, MAX, 0]: front, middle and append inserts
    '{MODE_INSERT,    7'd1,    VAL_MAX,       1'b1, ST_OK,       7'd0, 7'd1},
    '{MODE_INSERT,    7'd1,    VAL_MIN,       1'b1, ST_OK,       7'd0, 7'd2},
    '{MODE_INSERT,    7'd3,    32'sd0,        1'b1, ST_OK,       7'd0, 7'd3},
    '{MODE_INSERT,    7'd2,    -32'sd1,       1'b1, ST_OK,       7'd0, 7'd4},
    '{MODE_INSERT,    POS_ALL, 32'sd1,        1'b1, ST_BADPOS,   7'd0, 7'd4},
    '{MODE_DISPLAY,   7'd0,    32'sd0,        1'b0, ST_OK,       7'd0, 7'd0},
    '{MODE_SEARCH,    7'd0,    VAL_MIN,       1'b0, ST_OK,       7'd0, 7'd0},
    '{MODE_SEARCH,    7'd0,    32'sd0,        1'b0, ST_OK,       7'd0, 7'd0},
    '{MODE_SEARCH,    7'd0,    32'sd12345,    1'b1, ST_NOTFOUND, 7'd0, 7'd4},
    // delete position checks, then middle and tail deletes
    '{MODE_DELETE,    7'd0,    32'sd0,        1'b1, ST_BADPOS,   7'd0, 7'd4},
    '{MODE_DELETE,    7'd5,    32'sd0,        1'b1, ST_BADPOS,   7'd0, 7'd4},
    '{MODE_DELETE,    7'd2,    32'sd0,        1'b1, ST_OK,       7'd0, 7'd3},
    '{MODE_DELETE,    7'd3,    32'sd0,        1'b0, ST_OK,       7'd0, 7'd0},
    // undefined opcodes
    '{MODE_UNDEF_LO,  7'd1,    32'sd7,        1'b1, ST_BADPOS,   7'd0, 7'd2},
    '{MODE_UNDEF_MID, 7'd2,    VAL_MAX,       1'b1, ST_BADPOS,   7'd0, 7'd2},
    '{MODE_UNDEF_HI,  POS_ALL, -32'sd1,       1'b1, ST_BADPOS,   7'd0, 7'd2},
    // duplicate key: search must report the first match
    '{MODE_INSERT,    7'd2,    VAL_MAX,       1'b0, ST_OK,       7'd0, 7'd0},
    '{MODE_SEARCH,    7'd0,    VAL_MAX,       1'b0, ST_OK,       7'd0, 7'd0},
    '{MODE_DISPLAY,   7'd0,    32'sd0,        1'b0, ST_OK,       7'd0, 7'd0},
    '{MODE_CLEAR,     7'd0,    32'sd0,        1'b1, ST_OK,       7'd0, 7'd0},
    '{MODE_DISPLAY,   7'd0,    32'sd0,        1'b1, ST_EMPTY,    7'd0, 7'd0}
  };

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic [MODE_W-1:0]        mode_i      = '0;
  logic [POS_W-1:0]         position_i  = '0;
  logic signed [DATA_W-1:0] value_i     = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [STAT_W-1:0]        status_o;
  logic [POS_W-1:0]         found_position_o;
  logic signed [DATA_W-1:0] element_o;
  logic [ECNT_W-1:0]        element_count_o;
  logic                     last_o;

  // Array model state.
  logic signed [DATA_W-1:0] array_mem [DEPTH];
  int                       array_cnt = 0;
  int                       peak_cnt  = 0;

  result_beat_t             op_results [$];      // results of the op just modeled
  result_beat_t             pending_results [$]; // outstanding out beats, oldest first

  int  mismatches    = 0;
  int  beats_in      = 0;
  int  beats_checked = 0;
  int  status_seen [5] = '{default: 0};
  bit  steady        = 1'b0; // set: no idling on either side

  ordered_array_insert_delete_search_top uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("Regression FAIL");
    $finish;
  end

  // Idle length: mostly short, now and then a long one.
  function automatic int idle_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void add_result(status_e st, int found,
                                     logic signed [DATA_W-1:0] elem, bit last);
    result_beat_t b;
    b.status  = st;
    b.found   = POS_W'(found);
    b.element = elem;
    b.count   = ECNT_W'(array_cnt);
    b.last    = last;
    op_results.push_back(b);
  endfunction

  // Applies one op to the array model and lists its out beats in op_results.
  // Count in every beat is the count after the op.
  function automatic void model_array_op(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                                         logic signed [DATA_W-1:0] val);
    int p;
    int hit;
    p   = int'(pos);
    hit = 0;
    op_results.delete();
    case (mode)
      MODE_CLEAR: begin
        array_cnt = 0;
        add_result(ST_OK, 0, '0, 1'b1);
      end
      MODE_INSERT: begin
        // full check wins over the position check
        if (array_cnt >= DEPTH) add_result(ST_FULL, 0, '0, 1'b1);
        else if (p < 1 || p > array_cnt + 1) add_result(ST_BADPOS, 0, '0, 1'b1);
        else begin
          for (int i = array_cnt; i >= p; i--) array_mem[i] = array_mem[i-1];
          array_mem[p-1] = val;
          array_cnt++;
          add_result(ST_OK, 0, '0, 1'b1);
        end
      end
      MODE_DELETE: begin
        if (array_cnt == 0) add_result(ST_EMPTY, 0, '0, 1'b1);
        else if (p < 1 || p > array_cnt) add_result(ST_BADPOS, 0, '0, 1'b1);
        else begin
          for (int i = p - 1; i + 1 < array_cnt; i++) array_mem[i] = array_mem[i+1];
          array_cnt--;
          add_result(ST_OK, 0, '0, 1'b1);
        end
      end
      MODE_SEARCH: begin
        if (array_cnt == 0) add_result(ST_EMPTY, 0, '0, 1'b1);
        else begin
          for (int i = array_cnt - 1; i >= 0; i--) if (array_mem[i] == val) hit = i + 1;
          if (hit != 0) add_result(ST_OK, hit, '0, 1'b1);
          else add_result(ST_NOTFOUND, 0, '0, 1'b1);
        end
      end
      MODE_DISPLAY: begin
        if (array_cnt == 0) add_result(ST_EMPTY, 0, '0, 1'b1);
        else
          for (int i = 0; i < array_cnt; i++)
            add_result(ST_OK, 0, array_mem[i], i + 1 == array_cnt);
      end
      default: add_result(ST_BADPOS, 0, '0, 1'b1);
    endcase
    if (array_cnt > peak_cnt) peak_cnt = array_cnt;
  endfunction

  // Presents one in beat and returns at the edge that accepts it. Valid is
  // left high on return: the next call either reuses it back to back or
  // lowers it in the same step, so valid sees one assignment per step.
  task automatic send_beat(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                           logic signed [DATA_W-1:0] val);
    int gap;
    gap = (steady || $urandom_range(0, 99) < 50) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    position_i <= pos;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    beats_in++;
  endtask

  // Sends one op and queues its expected results: the typed single result
  // when given, else what the array model produces.
  task automatic issue_op(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                          logic signed [DATA_W-1:0] val, bit typed = 1'b0,
                          status_e st = ST_OK, logic [POS_W-1:0] found = '0,
                          logic [ECNT_W-1:0] cnt = '0);
    result_beat_t b;
    send_beat(mode, pos, val);
    model_array_op(mode, pos, val);
    if (typed) begin
      b.status  = st;
      b.found   = found;
      b.element = '0;
      b.count   = cnt;
      b.last    = 1'b1;
      pending_results.push_back(b);
    end else begin
      foreach (op_results[i]) pending_results.push_back(op_results[i]);
    end
  endtask

  // Small values give duplicate keys so first-match search gets exercised.
  function automatic logic signed [DATA_W-1:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom;
    if (r < 8) return $urandom_range(0, 7);
    if (r == 8) return ($urandom_range(0, 1) != 0) ? VAL_MAX : VAL_MIN;
    return -$signed(DATA_W'($urandom_range(1, 8)));
  endfunction

  function automatic logic [MODE_W-1:0] MODE_DXUNDEF();
    return MODE_W'($urandom_range(int'(MODE_UNDEF_LO), int'(MODE_UNDEF_HI)));
  endfunction

  // Weighted random op. Positions are mostly legal for the current fill,
  // the rest span the whole 7-bit field.
  task automatic issue_random_op(int w_ins, int w_del, int w_srch, int w_disp,
                                 int w_clr, int w_bad);
    int                       r;
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    r   = $urandom_range(0, w_ins + w_del + w_srch + w_disp + w_clr + w_bad - 1);
    pos = POS_W'($urandom);
    val = rand_value();
    if (r < w_ins) begin
      mode = MODE_INSERT;
      if ($urandom_range(0, 99) < 85 && array_cnt < DEPTH)
        pos = POS_W'($urandom_range(1, array_cnt + 1));
    end else if (r < w_ins + w_del) begin
      mode = MODE_DELETE;
      if ($urandom_range(0, 99) < 85 && array_cnt > 0)
        pos = POS_W'($urandom_range(1, array_cnt));
    end else if (r < w_ins + w_del + w_srch) begin
      mode = MODE_SEARCH;
      if ($urandom_range(0, 99) < 60 && array_cnt > 0)
        val = array_mem[$urandom_range(0, array_cnt - 1)];
    end else if (r < w_ins + w_del + w_srch + w_disp) begin
      mode = MODE_DISPLAY;
    end else if (r < w_ins + w_del + w_srch + w_disp + w_clr) begin
      mode = MODE_CLEAR;
    end else begin
      mode = MODE_DXUNDEF();
    end
    issue_op(mode, pos, val);
  endtask

  // Waits until every queued result has been seen (sender held idle).
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls on out_ready, none while steady.
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || steady) begin
      out_ready_i <= rst_ni;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < 30) begin
      out_ready_i <= 1'b0;
      stall_left = idle_len() - 1;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Scoreboard: each accepted out beat against the oldest expectation.
  always @(posedge clk_i) begin
    result_beat_t b;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected out beat: status %0d element %0d", status_o, element_o);
        mismatches++;
      end else begin
        b = pending_results.pop_front();
        beats_checked++;
        if (int'(status_o) < 5) status_seen[status_o]++;
        if (status_o !== b.status) begin
          $error("status: expected %0d, got %0d", b.status, status_o);
          mismatches++;
        end
        if (found_position_o !== b.found) begin
          $error("found_position: expected %0d, got %0d", b.found, found_position_o);
          mismatches++;
        end
        if (element_o !== b.element) begin
          $error("element: expected %0d, got %0d", b.element, element_o);
          mismatches++;
        end
        if (element_count_o !== b.count) begin
          $error("element_count: expected %0d, got %0d", b.count, element_count_o);
          mismatches++;
        end
        if (last_o !== b.last) begin
          $error("last: expected %0d, got %0d", b.last, last_o);
          mismatches++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, grow phase, fill to capacity and
  // probe the full array, a full drain, then churn with and without idling.
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_ops[i])
      issue_op(directed_ops[i].mode, directed_ops[i].pos, directed_ops[i].val,
               directed_ops[i].typed, directed_ops[i].status, directed_ops[i].found,
               directed_ops[i].count);

    // grow: mostly inserts so later ops see a deep array
    repeat (40) issue_random_op(70, 10, 10, 5, 1, 4);

    // fill to capacity with appends, then hit the full cases
    while (array_cnt < DEPTH) issue_op(MODE_INSERT, POS_W'(array_cnt + 1), rand_value());
    issue_op(MODE_INSERT, 7'd1, rand_value());
    issue_op(MODE_INSERT, 7'd0, rand_value());        // full check before position
    issue_op(MODE_INSERT, POS_ALL, rand_value());
    issue_op(MODE_SEARCH, 7'd0, array_mem[DEPTH-1]);
    issue_op(MODE_DISPLAY, 7'd0, '0);
    issue_op(MODE_DELETE, POS_W'(DEPTH), '0);
    issue_op(MODE_DELETE, 7'd1, '0);
    issue_op(MODE_INSERT, 7'd1, VAL_MIN);
    issue_op(MODE_INSERT, POS_W'(DEPTH), VAL_MAX);

    // hold the sender off until the block has emptied its output
    drain_results();

    // churn: a back-to-back stretch, then random idling again
    steady = 1'b1;
    repeat (20) issue_random_op(35, 35, 15, 6, 4, 5);
    steady = 1'b0;
    repeat (50) issue_random_op(35, 35, 15, 6, 4, 5);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d in beats, %0d out beats checked, peak fill %0d of %0d",
             beats_in, beats_checked, peak_cnt, DEPTH);
    $display("Statuses seen: ok %0d, full %0d, empty %0d, bad pos %0d, not found %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_BADPOS], status_seen[ST_NOTFOUND]);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

>>> ordered_array_insert_delete_search_top.f
hdl/oaids_pkg.sv
hdl/oaids_ram.sv
hdl/oaids_seq.sv
hdl/ordered_array_insert_delete_search_top.sv
hdl/oaids_chk.sv
tb/tb.sv
